[src/whp_pkg.sv]
// ----------------------------------------------------------------------------
// Whirlpool hash package
// Types, command codes and the S-box, C0 and mixing functions of the
// Whirlpool block cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package whp_pkg;

  // One input word and the eight-word digest.
  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        end_of_message;
  } in_t;

  typedef struct packed {
    logic [63:0] digest_0;
    logic [63:0] digest_1;
    logic [63:0] digest_2;
    logic [63:0] digest_3;
    logic [63:0] digest_4;
    logic [63:0] digest_5;
    logic [63:0] digest_6;
    logic [63:0] digest_7;
  } out_t;

  // Eight 64-bit lanes of a cipher state; lane 0 is element [0].
  typedef logic [7:0][63:0] lanes_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ABSORB,
    OP_PAD,
    OP_ZERO,
    OP_LEN,
    OP_INIT,
    OP_KEY,
    OP_STATE,
    OP_FINAL,
    OP_EMIT
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ABSORB,
    ST_PAD,
    ST_ZERO,
    ST_LEN,
    ST_INIT,
    ST_KEY,
    ST_STATE,
    ST_FINAL,
    ST_OUT
  } state_e;

  // Where the controller resumes after a compression.
  typedef enum logic [1:0] {
    RET_ABSORB,
    RET_PAD,
    RET_DONE
  } ret_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] len_idx;
    logic       zero_to_64;
  } cmd_t;

  typedef struct packed {
    logic block_full;
    logic fill_ge32;
    logic fill_at32;
    logic pend_empty;
    logic last;
    logic out_busy;
  } status_t;

  localparam int unsigned BlockBytes = 64;

  // Mini-boxes of the S-box construction.
  localparam logic [3:0] EBOX [16] = '{4'h1, 4'hB, 4'h9, 4'hC, 4'hD, 4'h6, 4'hF, 4'h3,
                                       4'hE, 4'h8, 4'h7, 4'h4, 4'hA, 4'h2, 4'h5, 4'h0};
  localparam logic [3:0] EBOX_INV [16] = '{4'hF, 4'h0, 4'hD, 4'h7, 4'hB, 4'hE, 4'h5, 4'hA,
                                           4'h9, 4'h2, 4'hC, 4'h1, 4'h3, 4'h4, 4'h8, 4'h6};
  localparam logic [3:0] RBOX [16] = '{4'h7, 4'hC, 4'hB, 4'hD, 4'hE, 4'h4, 4'h9, 4'hF,
                                       4'h6, 4'h3, 4'h8, 4'hA, 4'h2, 4'h5, 4'h1, 4'h0};

  function automatic logic [7:0] sbox(input logic [7:0] u);
    logic [3:0] a;
    logic [3:0] b;
    logic [3:0] r;
    a = EBOX[u[7:4]];
    b = EBOX_INV[u[3:0]];
    r = RBOX[a ^ b];
    return {EBOX[a ^ r], EBOX_INV[b ^ r]};
  endfunction

  // Multiply by x in GF(2^8) modulo x^8+x^4+x^3+x^2+1.
  function automatic logic [7:0] gf_double(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1D : 8'h00);
  endfunction

  // C0 table entry of byte v, rotated right by eight bits per position.
  function automatic logic [63:0] c0_rot(input int pos, input logic [7:0] v);
    logic [7:0]   s;
    logic [7:0]   s2;
    logic [7:0]   s4;
    logic [7:0]   s8;
    logic [63:0]  e;
    logic [127:0] ee;
    s  = sbox(v);
    s2 = gf_double(s);
    s4 = gf_double(s2);
    s8 = gf_double(s4);
    e  = {s, s, s4, s, s8, s4 ^ s, s2, s8 ^ s};
    ee = {e, e} >> (8 * pos);
    return ee[63:0];
  endfunction

  // One SubBytes, ShiftColumns and MixRows step over all eight lanes.
  function automatic lanes_t mix(input lanes_t w);
    lanes_t r;
    for (int i = 0; i < 8; i++) begin
      r[i] = '0;
      for (int t = 0; t < 8; t++) begin
        r[i] ^= c0_rot(t, w[3'(i - t)][63 - 8 * t -: 8]);
      end
    end
    return r;
  endfunction

  // Round constant of round rnd, counted from one.
  function automatic logic [63:0] round_const(input logic [7:0] rnd);
    logic [63:0] c;
    logic [7:0]  rb;
    rb = rnd - 8'd1;
    c  = '0;
    for (int i = 0; i < 8; i++) begin
      c = {c[55:0], sbox({rb[4:0], 3'(i)})};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[src/whp_ctrl.sv]
// ----------------------------------------------------------------------------
// Whirlpool hash controller
// Sequences word absorption, padding, the round loop and digest output.
// ----------------------------------------------------------------------------
`default_nettype none

module whp_ctrl #(
  parameter int unsigned ROUNDS = 10
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire whp_pkg::status_t              status_i,
  output whp_pkg::cmd_t                      cmd_o,
  output logic [$clog2(ROUNDS + 1) - 1:0]    round_o
);
  import whp_pkg::*;

  localparam int unsigned RW = $clog2(ROUNDS + 1);

  state_e        state_q, state_d;
  ret_e          ret_q, ret_d;
  logic          z64_q, z64_d;
  logic [1:0]    idx_q, idx_d;
  logic [RW-1:0] rnd_q, rnd_d;

  // State and loop registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= RET_ABSORB;
      z64_q   <= 1'b0;
      idx_q   <= '0;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      z64_q   <= z64_d;
      idx_q   <= idx_d;
      rnd_q   <= rnd_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d           = state_q;
    ret_d             = ret_q;
    z64_d             = z64_q;
    idx_d             = idx_q;
    rnd_d             = rnd_q;
    cmd_o.op          = OP_NONE;
    cmd_o.len_idx     = idx_q;
    cmd_o.zero_to_64  = z64_q;
    in_stall_o        = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_ABSORB;
        end
      end
      ST_ABSORB: begin
        if (status_i.block_full) begin
          ret_d   = RET_ABSORB;
          state_d = ST_INIT;
        end else if (status_i.pend_empty) begin
          state_d = status_i.last ? ST_PAD : ST_IDLE;
        end else begin
          cmd_o.op = OP_ABSORB;
        end
      end
      ST_PAD: begin
        // An extra block is needed when the marker lands past the middle.
        cmd_o.op = OP_PAD;
        z64_d    = status_i.fill_ge32;
        state_d  = ST_ZERO;
      end
      ST_ZERO: begin
        if (z64_q && status_i.block_full) begin
          ret_d   = RET_PAD;
          state_d = ST_INIT;
        end else if (!z64_q && status_i.fill_at32) begin
          idx_d   = '0;
          state_d = ST_LEN;
        end else begin
          cmd_o.op = OP_ZERO;
        end
      end
      ST_LEN: begin
        cmd_o.op = OP_LEN;
        idx_d    = idx_q + 2'd1;
        if (idx_q == 2'd3) begin
          ret_d   = RET_DONE;
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd_o.op = OP_INIT;
        rnd_d    = RW'(1);
        state_d  = ST_KEY;
      end
      ST_KEY: begin
        cmd_o.op = OP_KEY;
        state_d  = ST_STATE;
      end
      ST_STATE: begin
        cmd_o.op = OP_STATE;
        if (rnd_q == RW'(ROUNDS)) begin
          state_d = ST_FINAL;
        end else begin
          rnd_d   = rnd_q + RW'(1);
          state_d = ST_KEY;
        end
      end
      ST_FINAL: begin
        cmd_o.op = OP_FINAL;
        unique case (ret_q)
          RET_ABSORB: state_d = ST_ABSORB;
          RET_PAD: begin
            z64_d   = 1'b0;
            state_d = ST_ZERO;
          end
          RET_DONE:   state_d = ST_OUT;
          default:    state_d = ST_OUT;
        endcase
      end
      ST_OUT: begin
        if (!status_i.out_busy) begin
          cmd_o.op = OP_EMIT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign round_o = rnd_q;

endmodule

`default_nettype wire

[src/whp_datapath.sv]
// ----------------------------------------------------------------------------
// Whirlpool hash datapath
// Block buffer, bit counter, chain value and a shared round unit that does
// the key round and the state round in alternate cycles.
// ----------------------------------------------------------------------------
`default_nettype none

module whp_datapath #(
  parameter int unsigned ROUNDS = 10
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire whp_pkg::in_t                  in_data_i,
  input  wire whp_pkg::cmd_t                 cmd_i,
  input  wire logic [$clog2(ROUNDS + 1) - 1:0] round_i,
  output whp_pkg::status_t                   status_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output whp_pkg::out_t                      out_data_o
);
  import whp_pkg::*;

  logic [511:0] block_q, block_d;
  logic [6:0]   fill_q, fill_d;
  logic [63:0]  pend_q, pend_d;
  logic [3:0]   pcnt_q, pcnt_d;
  logic         last_q, last_d;
  logic [255:0] len_q, len_d;
  lanes_t       h_q, h_d;
  lanes_t       k_q, k_d;
  lanes_t       s_q, s_d;
  out_t         out_q, out_d;
  logic         ovld_q, ovld_d;

  logic [3:0]   sat_cnt;
  logic [6:0]   room;
  logic [6:0]   tgt;
  logic [3:0]   n;
  logic [63:0]  src;
  logic [6:0]   sh;
  lanes_t       blk;
  lanes_t       mix_in;
  lanes_t       mix_out;
  logic [63:0]  len_word;

  // Block buffer viewed as eight big-endian lanes.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      blk[i] = block_q[511 - 64 * i -: 64];
    end
  end

  assign sat_cnt = (in_data_i.byte_count > 4'd8) ? 4'd8 : in_data_i.byte_count;
  assign room    = 7'(BlockBytes) - fill_q;
  assign tgt     = cmd_i.zero_to_64 ? 7'd64 : 7'd32;

  // Bit count word for the length field, most significant first.
  always_comb begin
    unique case (cmd_i.len_idx)
      2'd0:    len_word = len_q[255:192];
      2'd1:    len_word = len_q[191:128];
      2'd2:    len_word = len_q[127:64];
      default: len_word = len_q[63:0];
    endcase
  end

  // Bytes to append this cycle and their source.
  always_comb begin
    n   = '0;
    src = pend_q;
    unique case (cmd_i.op)
      OP_ABSORB: begin
        n = ({3'b0, pcnt_q} > room) ? room[3:0] : pcnt_q;
      end
      OP_PAD: begin
        n   = 4'd1;
        src = {8'h80, 56'h0};
      end
      OP_ZERO: begin
        n   = ((tgt - fill_q) > 7'd8) ? 4'd8 : 4'((tgt - fill_q));
        src = '0;
      end
      OP_LEN: begin
        n   = 4'd8;
        src = len_word;
      end
      default: begin
        n = '0;
      end
    endcase
  end

  assign sh      = {n, 3'b000};
  assign mix_in  = (cmd_i.op == OP_KEY) ? k_q : s_q;
  assign mix_out = mix(mix_in);

  // Next values for every register.
  always_comb begin
    block_d = block_q;
    fill_d  = fill_q;
    pend_d  = pend_q;
    pcnt_d  = pcnt_q;
    last_d  = last_q;
    len_d   = len_q;
    h_d     = h_q;
    k_d     = k_q;
    s_d     = s_q;
    out_d   = out_q;
    ovld_d  = ovld_q && out_stall_i;
    if (n != 4'd0) begin
      block_d = (block_q << sh) | 512'(src >> (7'd64 - sh));
      fill_d  = fill_q + 7'(n);
    end
    unique case (cmd_i.op)
      OP_LOAD: begin
        pend_d = in_data_i.data_word;
        pcnt_d = sat_cnt;
        last_d = in_data_i.end_of_message;
        len_d  = len_q + 256'({sat_cnt, 3'b000});
      end
      OP_ABSORB: begin
        pend_d = pend_q << sh;
        pcnt_d = pcnt_q - n;
      end
      OP_INIT: begin
        k_d = h_q;
        s_d = blk ^ h_q;
      end
      OP_KEY: begin
        k_d    = mix_out;
        k_d[0] = mix_out[0] ^ round_const(8'(round_i));
      end
      OP_STATE: begin
        s_d = mix_out ^ k_q;
      end
      OP_FINAL: begin
        h_d    = h_q ^ s_q ^ blk;
        fill_d = '0;
      end
      OP_EMIT: begin
        out_d.digest_0 = h_q[0];
        out_d.digest_1 = h_q[1];
        out_d.digest_2 = h_q[2];
        out_d.digest_3 = h_q[3];
        out_d.digest_4 = h_q[4];
        out_d.digest_5 = h_q[5];
        out_d.digest_6 = h_q[6];
        out_d.digest_7 = h_q[7];
        ovld_d = 1'b1;
        h_d    = '0;
        len_d  = '0;
        fill_d = '0;
        last_d = 1'b0;
      end
      default: begin
        ovld_d = ovld_q && out_stall_i;
      end
    endcase
  end

  // Control and chaining registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      pcnt_q <= '0;
      last_q <= 1'b0;
      len_q  <= '0;
      h_q    <= '0;
      ovld_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      pcnt_q <= pcnt_d;
      last_q <= last_d;
      len_q  <= len_d;
      h_q    <= h_d;
      ovld_q <= ovld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    block_q <= block_d;
    pend_q  <= pend_d;
    k_q     <= k_d;
    s_q     <= s_d;
    out_q   <= out_d;
  end

  assign status_o.block_full = (fill_q == 7'(BlockBytes));
  assign status_o.fill_ge32  = (fill_q >= 7'd32);
  assign status_o.fill_at32  = (fill_q == 7'd32);
  assign status_o.pend_empty = (pcnt_q == 4'd0);
  assign status_o.last       = last_q;
  assign status_o.out_busy   = ovld_q && out_stall_i;

  assign out_valid_o = ovld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[src/whirlpool_512_hash.sv]
// ----------------------------------------------------------------------------
// Whirlpool-512 hash
// Streams message words into 64-byte blocks and returns the 512-bit digest.
// ----------------------------------------------------------------------------
// Each accepted word is loaded, its bytes are appended to each block that
// they touch, and the word is seen drained before the input opens again.
// A block that fills is noticed and compressed; one shared mixing unit does
// the key round and the state round of each round in turn. The last word
// adds padding (a marker byte, up to eight zero bytes a cycle, a check each
// time a zero fill reaches its end, four words of bit count), one or two
// compressions and an output step. The digest sits in an output register,
// so the next message may start while it waits to be taken; a second
// digest waits for the first.
`default_nettype none

module whirlpool_512_hash #(
  parameter int unsigned ROUNDS = 10
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire whp_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output whp_pkg::out_t      out_data_o
);
  import whp_pkg::*;

  cmd_t                            cmd;
  status_t                         status;
  logic [$clog2(ROUNDS + 1) - 1:0] round;

  // Sequencer.
  whp_ctrl #(
    .ROUNDS (ROUNDS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd),
    .round_o    (round)
  );

  // Buffer, counter and round unit.
  whp_datapath #(
    .ROUNDS (ROUNDS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .round_i     (round),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

[tb/sv/whirlpool_512_hash_tb.sv]
// ----------------------------------------------------------------------------
// Whirlpool-512 hash testbench
// Sends message words over the valid/stall input channel and compares every
// digest with a predictor that keeps its own chain value, block buffer and
// bit count. Covers directed corner messages, then random messages.
// ----------------------------------------------------------------------------
`default_nettype none

module whirlpool_512_hash_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import whp_pkg::*;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned RandWords = 1200;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  whirlpool_512_hash #(.ROUNDS(NumRounds)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  // Predictor state.
  logic [63:0] hp_chain [8];
  logic [7:0]  hp_buf [64];
  int unsigned hp_fill;
  logic [255:0] hp_bits;

  out_t digest_q[$];
  int unsigned err_count;
  int unsigned digest_count;
  int unsigned words_sent;
  bit stim_done;
  bit hold_rx;

  // Separate versions of the cipher pieces, written for the predictor.
  function automatic logic [7:0] hp_sub(input logic [7:0] u);
    logic [3:0] e [16];
    logic [3:0] ei [16];
    logic [3:0] rr [16];
    logic [3:0] a, b, r;
    e  = '{4'h1, 4'hB, 4'h9, 4'hC, 4'hD, 4'h6, 4'hF, 4'h3,
           4'hE, 4'h8, 4'h7, 4'h4, 4'hA, 4'h2, 4'h5, 4'h0};
    ei = '{4'hF, 4'h0, 4'hD, 4'h7, 4'hB, 4'hE, 4'h5, 4'hA,
           4'h9, 4'h2, 4'hC, 4'h1, 4'h3, 4'h4, 4'h8, 4'h6};
    rr = '{4'h7, 4'hC, 4'hB, 4'hD, 4'hE, 4'h4, 4'h9, 4'hF,
           4'h6, 4'h3, 4'h8, 4'hA, 4'h2, 4'h5, 4'h1, 4'h0};
    a = e[u[7:4]];
    b = ei[u[3:0]];
    r = rr[a ^ b];
    return {e[a ^ r], ei[b ^ r]};
  endfunction

  function automatic logic [7:0] hp_x2(input logic [7:0] x);
    return x[7] ? ({x[6:0], 1'b0} ^ 8'h1D) : {x[6:0], 1'b0};
  endfunction

  function automatic logic [63:0] hp_col(input int unsigned pos, input logic [7:0] v);
    logic [7:0] s, s2, s4, s8;
    logic [63:0] e;
    s  = hp_sub(v);
    s2 = hp_x2(s);
    s4 = hp_x2(s2);
    s8 = hp_x2(s4);
    e  = {s, s, s4, s, s8, s4 ^ s, s2, s8 ^ s};
    if (pos == 0) return e;
    return (e >> (8 * pos)) | (e << (64 - 8 * pos));
  endfunction

  function automatic lanes_t hp_round(input lanes_t w);
    lanes_t r;
    for (int i = 0; i < 8; i++) begin
      r[i] = '0;
      for (int t = 0; t < 8; t++) begin
        r[i] ^= hp_col(t, w[(i - t) & 7][63 - 8 * t -: 8]);
      end
    end
    return r;
  endfunction

  // Compress the buffered block into the chain value.
  task automatic hp_compress();
    lanes_t k, s, blk, t;
    logic [63:0] rc;
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8; j++) blk[i][63 - 8 * j -: 8] = hp_buf[8 * i + j];
      k[i] = hp_chain[i];
      s[i] = blk[i] ^ k[i];
    end
    for (int r = 1; r <= NumRounds; r++) begin
      rc = '0;
      for (int i = 0; i < 8; i++) rc = {rc[55:0], hp_sub(8'(8 * (r - 1) + i))};
      k = hp_round(k);
      k[0] ^= rc;
      t = hp_round(s);
      for (int i = 0; i < 8; i++) s[i] = t[i] ^ k[i];
    end
    for (int i = 0; i < 8; i++) hp_chain[i] ^= s[i] ^ blk[i];
    hp_fill = 0;
  endtask

  // Absorb one word; queue a digest when it ends the message.
  task automatic hp_absorb(input in_t w);
    int unsigned n;
    out_t d;
    n = (w.byte_count > 8) ? 8 : w.byte_count;
    for (int i = 0; i < n; i++) begin
      hp_buf[hp_fill] = w.data_word[63 - 8 * i -: 8];
      hp_fill++;
      if (hp_fill == 64) hp_compress();
    end
    hp_bits += 256'(8 * n);
    if (!w.end_of_message) return;
    hp_buf[hp_fill] = 8'h80;
    for (int i = hp_fill + 1; i < 64; i++) hp_buf[i] = '0;
    if (63 - hp_fill < 32) begin
      hp_compress();
      for (int i = 0; i < 64; i++) hp_buf[i] = '0;
    end
    for (int i = 0; i < 32; i++) hp_buf[32 + i] = hp_bits[255 - 8 * i -: 8];
    hp_compress();
    d = {hp_chain[0], hp_chain[1], hp_chain[2], hp_chain[3],
         hp_chain[4], hp_chain[5], hp_chain[6], hp_chain[7]};
    digest_q.push_back(d);
    for (int i = 0; i < 8; i++) hp_chain[i] = '0;
    hp_bits = '0;
    hp_fill = 0;
  endtask

  // Directed words: empty message, one of each byte count, the 31/32-byte
  // padding boundary, oversized counts and bytes beyond the count.
  typedef struct {
    in_t         w;
    bit          known;
    logic [63:0] d0;
  } row_t;
  row_t dir_rows[$];

  task automatic add_row(input logic [63:0] dw, input logic [3:0] bc, input logic eom);
    row_t r;
    r.w = '{data_word: dw, byte_count: bc, end_of_message: eom};
    r.known = 1'b0;
    r.d0 = '0;
    dir_rows.push_back(r);
  endtask

  // Valid stays high into the next word when there is no gap.
  task automatic send_word(input in_t w);
    int unsigned gap;
    gap = $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    hp_absorb(w);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
    @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random stalls, one long hold-off while hold_rx is set.
  initial begin
    int unsigned wait_cycles;
    out_stall_i = 1'b1;
    forever begin
      @(negedge clk_i);
      if (hold_rx) out_stall_i <= 1'b1;
      else begin
        wait_cycles = $urandom_range(0, 5);
        if (wait_cycles != 0 && ($urandom_range(0, 3) != 0)) begin
          out_stall_i <= 1'b1;
          repeat (wait_cycles - 1) @(negedge clk_i);
        end else out_stall_i <= 1'b0;
      end
    end
  end

  // Digest checker.
  always @(posedge clk_i) begin
    out_t exp_d;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (digest_q.size() == 0) begin
        $display("%0t: digest with none expected: %h", $time, out_data_o);
        err_count++;
      end else begin
        exp_d = digest_q.pop_front();
        digest_count++;
        if (exp_d.digest_0 != out_data_o.digest_0) begin
          $display("%0t: digest_0 expected %h got %h", $time, exp_d.digest_0,
                   out_data_o.digest_0); err_count++; end
        if (exp_d.digest_1 != out_data_o.digest_1) begin
          $display("%0t: digest_1 expected %h got %h", $time, exp_d.digest_1,
                   out_data_o.digest_1); err_count++; end
        if (exp_d.digest_2 != out_data_o.digest_2) begin
          $display("%0t: digest_2 expected %h got %h", $time, exp_d.digest_2,
                   out_data_o.digest_2); err_count++; end
        if (exp_d.digest_3 != out_data_o.digest_3) begin
          $display("%0t: digest_3 expected %h got %h", $time, exp_d.digest_3,
                   out_data_o.digest_3); err_count++; end
        if (exp_d.digest_4 != out_data_o.digest_4) begin
          $display("%0t: digest_4 expected %h got %h", $time, exp_d.digest_4,
                   out_data_o.digest_4); err_count++; end
        if (exp_d.digest_5 != out_data_o.digest_5) begin
          $display("%0t: digest_5 expected %h got %h", $time, exp_d.digest_5,
                   out_data_o.digest_5); err_count++; end
        if (exp_d.digest_6 != out_data_o.digest_6) begin
          $display("%0t: digest_6 expected %h got %h", $time, exp_d.digest_6,
                   out_data_o.digest_6); err_count++; end
        if (exp_d.digest_7 != out_data_o.digest_7) begin
          $display("%0t: digest_7 expected %h got %h", $time, exp_d.digest_7,
                   out_data_o.digest_7); err_count++; end
      end
    end
  end

  // Stimulus.
  initial begin
    in_t w;
    int unsigned msg_words;
    logic [63:0] dw;
    bit hold_done;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    hold_rx = 1'b0;
    hold_done = 1'b0;
    stim_done = 1'b0;
    err_count = 0;
    digest_count = 0;
    words_sent = 0;
    for (int i = 0; i < 8; i++) hp_chain[i] = '0;
    for (int i = 0; i < 64; i++) hp_buf[i] = '0;
    hp_fill = 0;
    hp_bits = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty message.
    add_row(64'h0, 4'd0, 1'b1);
    // Each byte count with end of message, all ones and all zeros data.
    for (int n = 1; n <= 8; n++)
      add_row((n % 2) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0, 4'(n), 1'b1);
    // Zero bytes without end is ignored; oversized count saturates.
    add_row(64'h0123_4567_89AB_CDEF, 4'd0, 1'b0);
    add_row(64'hFEDC_BA98_7654_3210, 4'd15, 1'b0);
    add_row(64'hA5A5_A5A5_A5A5_A5A5, 4'd9, 1'b1);
    // 31-byte message: the length still fits behind the marker.
    for (int i = 0; i < 3; i++) add_row(64'h0F1E_2D3C_4B5A_6978, 4'd8, 1'b0);
    add_row(64'h8796_A5B4_C3D2_E1F0, 4'd7, 1'b1);
    // 32-byte message: the marker forces an extra block.
    for (int i = 0; i < 3; i++) add_row(64'h1357_9BDF_2468_ACE0, 4'd8, 1'b0);
    add_row(64'hC3C3_3C3C_C3C3_3C3C, 4'd8, 1'b1);
    // 56-byte message: padding spills into an extra block.
    for (int i = 0; i < 6; i++) add_row(64'h5555_AAAA_5555_AAAA, 4'd8, 1'b0);
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
    // Exactly one full block, then an empty last word.
    for (int i = 0; i < 8; i++) add_row(64'h8000_0000_0000_0001, 4'd8, 1'b0);
    add_row(64'h0, 4'd0, 1'b1);

    foreach (dir_rows[i]) send_word(dir_rows[i].w);

    // Random messages; long pressure hold-off partway through.
    while (words_sent < RandWords + dir_rows.size()) begin
      msg_words = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
                                              : $urandom_range(1, 10);
      if (words_sent > 300 && !hold_done) begin
        hold_done = 1'b1;
        fork
          begin
            hold_rx = 1'b1;
            repeat (400) @(posedge clk_i);
            hold_rx = 1'b0;
          end
        join_none
      end
      for (int k = 0; k < msg_words; k++) begin
        dw = {$urandom, $urandom};
        w.data_word = dw;
        w.end_of_message = (k == msg_words - 1);
        case ($urandom_range(0, 9))
          0: w.byte_count = 4'($urandom_range(9, 15));
          1: w.byte_count = 4'($urandom_range(0, 7));
          default: w.byte_count = 4'd8;
        endcase
        send_word(w);
      end
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // End of run.
  initial begin
    wait (stim_done);
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Covered %0d words and %0d digests: empty, short, padding-boundary,",
             words_sent, digest_count);
    $display("multi-block and oversized-count messages under random stalls.");
    if (err_count == 0) $display("whirlpool_512_hash_tb: done, clean");
    else $display("whirlpool_512_hash_tb: done, errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("whirlpool_512_hash_tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
